// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the RTL of the keyed-removal queue.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define LQKR_ASSERT(lbl, clk_sig, rstn_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (prop)) \
        else $error(msg);

// Checks that a condition implies another one in the next cycle.
`define LQKR_ASSERT_NEXT(lbl, clk_sig, rstn_sig, cond, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (cond) |=> (prop)) else $error(msg);

`endif

// File: rtl/lqkr_pkg.sv
// ----------------------------------------------------------------------------
// lqkr_pkg
// Types and codes shared by the keyed-removal queue and its cells.
// ----------------------------------------------------------------------------
package lqkr_pkg;

    typedef logic signed [31:0] word_t;

    typedef enum logic [1:0] {
        FN_PUSH   = 2'd0,
        FN_POP    = 2'd1,
        FN_REMOVE = 2'd2
    } func_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_NOKEY = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } state_t;

    typedef enum logic [2:0] {
        CC_HOLD,
        CC_LOAD,
        CC_SHIFT_ALL,
        CC_CLEAR,
        CC_PROP,
        CC_SHIFT_FLAG
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t cmd;
        word_t     wdata;
        word_t     key;
    } cell_ctrl_t;

endpackage

// File: rtl/lqkr_if.sv
// ----------------------------------------------------------------------------
// lqkr_req_if / lqkr_rsp_if
// Valid/ready channels for queue requests and their results.
// ----------------------------------------------------------------------------
interface lqkr_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic signed [31:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface lqkr_rsp_if #(
    parameter int OCC_W = 5
);
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] data;
    logic [OCC_W-1:0]   occupancy;
    logic signed [31:0] head_value;

    modport source (output valid, output status, output data, output occupancy,
                    output head_value, input ready);
    modport sink   (input valid, input status, input data, input occupancy,
                    input head_value, output ready);
endinterface

// File: rtl/linear_queue_with_keyed_removal.sv
// ----------------------------------------------------------------------------
// linear_queue_with_keyed_removal
// Linear queue with push, pop and remove-first-by-key, built as a row of
// slot cells that shift toward the head.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  req     | in  | func, value
//  rsp     | out | status, data, occupancy, head_value
//
//  A removal clears the cell flags, lets the found flag ripple one cell a cycle
//  up the row in the scan state, and shifts the matched entry out in the commit
//  state.
//  Reset clears the head and fill counters and the flags; slots are not reset.
//  A new request is taken while a result waits only if it is taken that cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module linear_queue_with_keyed_removal
    import lqkr_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    lqkr_req_if.sink  req,
    lqkr_rsp_if.source rsp
);

    localparam int PTR_W = $clog2(DEPTH + 1);
    localparam int CNT_W = $clog2(DEPTH);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  fill_reg, fill_next;
    word_t             key_reg;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        status_reg, status_next;
    word_t             data_reg, data_next;
    logic [PTR_W-1:0]  occ_out_reg, occ_out_next;
    word_t             head_val_reg, head_val_next;

    cell_ctrl_t        ctrl;
    logic              load_out;
    logic              accept;
    logic [PTR_W-1:0]  occ;
    word_t             cell_value [DEPTH];
    logic              cell_flag  [DEPTH];

    assign occ    = fill_reg - head_reg;
    assign accept = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        word_t upper;
        logic  lower;
        if (i == DEPTH - 1)
        begin : g_top
            assign upper = '0;
        end
        else
        begin : g_mid
            assign upper = cell_value[i+1];
        end
        if (i == 0)
        begin : g_bot
            assign lower = 1'b0;
        end
        else
        begin : g_up
            assign lower = cell_flag[i-1];
        end
        lqkr_cell #(
            .INDEX (i),
            .PTR_W (PTR_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .occ         (occ),
            .upper_value (upper),
            .lower_flag  (lower),
            .value       (cell_value[i]),
            .flag        (cell_flag[i])
        );
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (accept && (func_t'(req.func) == FN_REMOVE) && (occ != '0))
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DEPTH - 1))
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs: cell commands, counters and the result.
    always_comb
    begin
        ctrl.cmd      = CC_HOLD;
        ctrl.wdata    = req.value;
        ctrl.key      = key_reg;
        load_out      = 1'b0;
        head_next     = head_reg;
        fill_next     = fill_reg;
        status_next   = ST_OK;
        data_next     = '0;
        occ_out_next  = occ;
        head_val_next = (occ == '0) ? word_t'(0) : cell_value[0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (func_t'(req.func))
                        FN_PUSH:
                        begin
                            load_out = 1'b1;
                            if (fill_reg == PTR_W'(DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ctrl.cmd     = CC_LOAD;
                                fill_next    = fill_reg + 1'b1;
                                occ_out_next = occ + 1'b1;
                                if (occ == '0)
                                begin
                                    head_val_next = req.value;
                                end
                            end
                        end
                        FN_POP:
                        begin
                            load_out = 1'b1;
                            if (occ == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                ctrl.cmd      = CC_SHIFT_ALL;
                                data_next     = cell_value[0];
                                head_next     = head_reg + 1'b1;
                                occ_out_next  = occ - 1'b1;
                                head_val_next = (occ == PTR_W'(1)) ? word_t'(0)
                                                                   : cell_value[1];
                            end
                        end
                        FN_REMOVE:
                        begin
                            if (occ == '0)
                            begin
                                load_out    = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                ctrl.cmd = CC_CLEAR;
                            end
                        end
                        default:
                        begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                ctrl.cmd = CC_PROP;
            end
            S_COMMIT:
            begin
                load_out = 1'b1;
                // The top flag is set when any live entry matched the key.
                if (cell_flag[DEPTH-1])
                begin
                    ctrl.cmd     = CC_SHIFT_FLAG;
                    fill_next    = fill_reg - 1'b1;
                    occ_out_next = occ - 1'b1;
                    if (occ == PTR_W'(1))
                    begin
                        head_val_next = '0;
                    end
                    else
                    begin
                        head_val_next = cell_flag[0] ? cell_value[1] : cell_value[0];
                    end
                end
                else
                begin
                    status_next = ST_NOKEY;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= req.value;
        end
        if (load_out)
        begin
            status_reg   <= status_next;
            data_reg     <= data_next;
            occ_out_reg  <= occ_out_next;
            head_val_reg <= head_val_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.data       = data_reg;
    assign rsp.occupancy  = occ_out_reg;
    assign rsp.head_value = head_val_reg;

    `LQKR_ASSERT(a_ptr_order, clk, rst_n,
        (head_reg <= fill_reg) && (fill_reg <= PTR_W'(DEPTH)),
        "head or fill counter out of order")
    `LQKR_ASSERT(a_accept_idle, clk, rst_n,
        !accept || (state_reg == S_IDLE),
        "request taken while a removal is in progress")
    `LQKR_ASSERT_NEXT(a_commit_result, clk, rst_n,
        state_reg == S_COMMIT, rsp.valid && (state_reg == S_IDLE),
        "removal finished without a result")
    `LQKR_ASSERT(a_scan_no_result, clk, rst_n,
        (state_reg != S_SCAN) || !load_out,
        "result produced during the key scan")

endmodule

// File: rtl/lqkr_cell.sv
// ----------------------------------------------------------------------------
// lqkr_cell
// One queue slot: holds an entry, compares it with the key and passes a
// found-at-or-below flag up the row.
// ----------------------------------------------------------------------------
module lqkr_cell
    import lqkr_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int PTR_W = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    input  logic [PTR_W-1:0] occ,
    input  word_t            upper_value,
    input  logic             lower_flag,
    output word_t            value,
    output logic             flag
);

    word_t value_reg, value_next;
    logic  flag_reg, flag_next;
    logic  live;
    logic  match;

    // Live entries always sit packed at the low end of the row.
    assign live  = PTR_W'(INDEX) < occ;
    assign match = live && (value_reg == ctrl.key);

    always_comb
    begin
        value_next = value_reg;
        flag_next  = flag_reg;
        case (ctrl.cmd)
            CC_LOAD:
            begin
                if (PTR_W'(INDEX) == occ)
                begin
                    value_next = ctrl.wdata;
                end
            end
            CC_SHIFT_ALL:
            begin
                value_next = upper_value;
            end
            CC_CLEAR:
            begin
                flag_next = 1'b0;
            end
            CC_PROP:
            begin
                flag_next = match || lower_flag;
            end
            CC_SHIFT_FLAG:
            begin
                if (flag_reg)
                begin
                    value_next = upper_value;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
        end
        else
        begin
            flag_reg <= flag_next;
        end
    end

    assign value = value_reg;
    assign flag  = flag_reg;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives push, pop and keyed-removal requests into the linear queue with
// random gaps and result stalls. A shadow copy of the queue predicts each
// result, and every result is checked field by field in order.
// ----------------------------------------------------------------------------
import lqkr_pkg::*;

typedef struct packed {
    logic [1:0] status;
    word_t      data;
    logic [4:0] occupancy;
    word_t      head_value;
} queue_result_t;

class queue_shadow #(int DEPTH = 16);
    word_t         slots [DEPTH];
    int            head;
    int            fill;
    queue_result_t pending_results [$];
    int            mismatch_count;

    function new();
        head = 0;
        fill = 0;
        mismatch_count = 0;
        foreach (slots[i]) slots[i] = '0;
    endfunction

    function bit is_empty();
        return fill <= head;
    endfunction

    // Any entry between head and fill, for removals that should hit.
    function word_t live_key();
        return slots[$urandom_range(head, fill - 1)];
    endfunction

    function void note_request(logic [1:0] fn, word_t key);
        queue_result_t want;
        int            pos;
        want = '0;
        want.status = ST_OK;
        case (fn)
            FN_PUSH:
            begin
                if (fill >= DEPTH)
                begin
                    want.status = ST_FULL;
                end
                else
                begin
                    slots[fill] = key;
                    fill++;
                end
            end
            FN_POP:
            begin
                if (is_empty())
                begin
                    want.status = ST_EMPTY;
                end
                else
                begin
                    want.data = slots[head];
                    head++;
                end
            end
            FN_REMOVE:
            begin
                if (is_empty())
                begin
                    want.status = ST_EMPTY;
                end
                else
                begin
                    pos = fill;
                    for (int i = head; i < fill; i++)
                    begin
                        if (slots[i] == key)
                        begin
                            pos = i;
                            break;
                        end
                    end
                    if (pos >= fill)
                    begin
                        want.status = ST_NOKEY;
                    end
                    else
                    begin
                        for (int i = pos; i + 1 < fill; i++)
                            slots[i] = slots[i + 1];
                        fill--;
                    end
                end
            end
            default:
            begin
                // The unused code leaves the queue alone.
            end
        endcase
        want.occupancy = 5'(fill - head);
        want.head_value = (!is_empty() && head < DEPTH) ? slots[head] : '0;
        pending_results.push_back(want);
    endfunction

    function void check_result(queue_result_t got);
        queue_result_t want;
        if (pending_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected result: status %0d data %0d occupancy %0d head %0d",
                         got.status, got.data, got.occupancy, got.head_value);
            return;
        end
        want = pending_results.pop_front();
        if (got.status !== want.status || got.data !== want.data ||
            got.occupancy !== want.occupancy || got.head_value !== want.head_value)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
            begin
                $display("mismatch: expected status %0d data %0d occupancy %0d head %0d",
                         want.status, want.data, want.occupancy, want.head_value);
                $display("          got status %0d data %0d occupancy %0d head %0d",
                         got.status, got.data, got.occupancy, got.head_value);
            end
        end
    endfunction
endclass

module testbench;

    localparam int DEPTH = 16;
    localparam logic [1:0] FN_NOP = 2'd3;
    localparam int RANDOM_ITEMS = 1120;
    localparam int IDLE_LIMIT = 500;

    logic clk;
    logic rst_n;
    bit   calm;
    int   idle_cycles;

    queue_shadow #(DEPTH) shadow;

    lqkr_req_if req_ch ();
    lqkr_rsp_if #(.OCC_W(5)) rsp_ch ();

    linear_queue_with_keyed_removal #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic [1:0] fn, input word_t v);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.func = fn;
        req_ch.value = v;
        req_ch.valid = 1'b1;
        forever
        begin
            @(posedge clk);
            if (req_ch.ready)
                break;
        end
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_ch.valid = 1'b0;
        while (shadow.pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_opening();
        word_t opening_vals [16];
        opening_vals = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, -1, 7, 3, 7, 1,
                         2, 7, 4, 5, 6, 8, 9, 10};
        send_request(FN_POP, 0);
        send_request(FN_REMOVE, 5);
        send_request(FN_NOP, -1);
        foreach (opening_vals[i])
            send_request(FN_PUSH, opening_vals[i]);
        send_request(FN_PUSH, 42);
        send_request(FN_REMOVE, 12345);
        send_request(FN_REMOVE, 32'sh8000_0000);
        // Three entries hold 7; only the first one goes.
        send_request(FN_REMOVE, 7);
        send_request(FN_REMOVE, 10);
        send_request(FN_POP, 0);
        send_request(FN_NOP, 0);
        send_request(FN_PUSH, 11);
    endtask

    function automatic word_t draw_value();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2, 3, 4, 5: return word_t'(int'($urandom_range(0, 7)) - 4);
            default: return $urandom;
        endcase
    endfunction

    task automatic run_random();
        int r;
        int push_share;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = ((n / 100) % 4) == 1;
            if (n % 300 == 150)
                wait_drained();
            // Alternate between filling and draining phases so both ends are hit.
            push_share = ((n / 80) % 2 == 0) ? 70 : 30;
            r = $urandom_range(0, 99);
            // Pops are kept rare: every pop costs one slot for the rest of the run.
            if (r < 2 && shadow.head < 6)
                send_request(FN_POP, draw_value());
            else if (r < 5)
                send_request(FN_NOP, draw_value());
            else if (r < push_share)
                send_request(FN_PUSH, draw_value());
            else if (!shadow.is_empty() && r < 92)
                send_request(FN_REMOVE, shadow.live_key());
            else
                send_request(FN_REMOVE, draw_value());
        end
        calm = 1'b0;
    endtask

    // Fill the queue, then pop it dry so head and fill both reach the end.
    task automatic run_closing();
        while (shadow.fill < DEPTH)
            send_request(FN_PUSH, draw_value());
        while (!shadow.is_empty())
            send_request(FN_POP, 0);
        send_request(FN_PUSH, 1);
        send_request(FN_POP, 0);
        send_request(FN_REMOVE, 1);
        send_request(FN_NOP, 0);
    endtask

    always @(posedge clk)
    begin : monitor_b
        queue_result_t got;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                shadow.note_request(req_ch.func, req_ch.value);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.status = rsp_ch.status;
                got.data = rsp_ch.data;
                got.occupancy = rsp_ch.occupancy;
                got.head_value = rsp_ch.head_value;
                shadow.check_result(got);
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL linear_queue_with_keyed_removal");
                $finish;
            end
        end
    end

    initial
    begin
        int gap;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        rsp_ch.ready = 1'b1;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                @(negedge clk);
                gap = calm ? 0 : $urandom_range(0, 3);
                if (gap > 0)
                begin
                    rsp_ch.ready = 1'b0;
                    repeat (gap) @(negedge clk);
                    rsp_ch.ready = 1'b1;
                end
            end
        end
    end

    initial
    begin
        int settle;
        shadow = new();
        calm = 1'b0;
        idle_cycles = 0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.func = FN_PUSH;
        req_ch.value = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        run_opening();
        run_random();
        run_closing();

        wait_drained();
        settle = DEPTH + 4;
        repeat (settle) @(negedge clk);
        if (shadow.mismatch_count == 0 && shadow.pending_results.size() == 0)
            $display("PASS linear_queue_with_keyed_removal");
        else
            $display("FAIL linear_queue_with_keyed_removal");
        $finish;
    end

endmodule
